// ===== rtl/ptp_pkg.sv =====
package ptp_pkg;

	// Field widths fixed by the interface
	localparam int OP_W     = 3;
	localparam int ID_W     = 32;
	localparam int PORT_PAY_W = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;

	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_PAYLOAD_WIDTH = 32;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [PRIO_W-1:0]   prio_t;
	typedef logic [ID_W-1:0]     id_t;

	localparam op_t OP_ADD         = 3'd0;
	localparam op_t OP_PROMOTE     = 3'd1;
	localparam op_t OP_GET_MAX     = 3'd2;
	localparam op_t OP_POP_MAX     = 3'd3;
	localparam op_t OP_IS_VALID    = 3'd4;
	localparam op_t OP_GET_PAYLOAD = 3'd5;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_EMPTY   = 2'd2;
	localparam status_t ST_UNKNOWN = 2'd3;

	localparam prio_t PRIO_MAX = {PRIO_W{1'b1}};

	// Controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic start;
		logic rd_en;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/ptp_if.sv =====
interface ptp_req_if import ptp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	op_t                   operation;
	id_t                   entry_id;
	logic [PORT_PAY_W-1:0] payload_in;

	modport source (output valid, output operation, output entry_id, output payload_in,
		input ready);
	modport sink (input valid, input operation, input entry_id, input payload_in,
		output ready);
endinterface

interface ptp_rsp_if import ptp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	id_t                   id_out;
	logic [PORT_PAY_W-1:0] payload_out;
	prio_t                 priority_out;
	logic                  is_valid_out;

	modport source (output valid, output status, output id_out, output payload_out,
		output priority_out, output is_valid_out, input ready);
	modport sink (input valid, input status, input id_out, input payload_out,
		input priority_out, input is_valid_out, output ready);
endinterface

// ===== rtl/ptp_ctrl.sv =====
module ptp_ctrl import ptp_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  stat_t         stat,
	output cmd_t          cmd,
	output logic [AW-1:0] addr
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;

	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_WRITE;
				S_WRITE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.clear_wr = (state_q == S_CLEAR);
		cmd.start    = (state_q == S_IDLE) && req_valid;
		cmd.rd_en    = (state_q == S_SCAN);
		cmd.commit   = (state_q == S_WRITE) && stat.out_free;
	end

	assign req_ready = (state_q == S_IDLE);
	assign addr      = cnt_q;

endmodule

// ===== rtl/ptp_dp.sv =====
module ptp_dp import ptp_pkg::*; #(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [AW-1:0]         addr,
	output stat_t                 stat,
	input  op_t                   operation,
	input  id_t                   entry_id,
	input  logic [PORT_PAY_W-1:0] payload_in,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output status_t               status,
	output id_t                   id_out,
	output logic [PORT_PAY_W-1:0] payload_out,
	output prio_t                 priority_out,
	output logic                  is_valid_out
);

	localparam int SW = (PAYLOAD_WIDTH < PORT_PAY_W) ? PAYLOAD_WIDTH : PORT_PAY_W;

	// Slot table
	logic          used_mem [CAPACITY];
	logic [SW-1:0] pay_mem  [CAPACITY];
	prio_t         pri_mem  [CAPACITY];
	id_t           seq_mem  [CAPACITY];

	// Captured request
	op_t           op_q;
	id_t           id_q;
	logic [SW-1:0] pay_q;
	id_t           next_seq_q;

	// Read stage
	logic          eval_s1;
	logic [AW-1:0] idx_s1;
	logic          used_s1;
	logic [SW-1:0] pay_s1;
	prio_t         pri_s1;
	id_t           seq_s1;

	// Selected slot
	logic          sel_fnd_q;
	logic [AW-1:0] sel_idx_q;
	logic [SW-1:0] sel_pay_q;
	prio_t         sel_pri_q;
	id_t           sel_seq_q;

	logic          take;
	prio_t         pri_inc;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_used;
	logic [SW-1:0] wr_pay;
	prio_t         wr_pri;
	id_t           wr_seq;

	status_t               res_status;
	id_t                   res_id;
	logic [PORT_PAY_W-1:0] res_pay;
	prio_t                 res_pri;
	logic                  res_valid;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= operation;
			id_q  <= entry_id;
			pay_q <= payload_in[SW-1:0];
		end
	end

	// Per-slot pick rule: first free slot, first id match, or running maximum
	always_comb begin
		take = 1'b0;
		if (op_q == OP_ADD) begin
			take = !sel_fnd_q && !used_s1;
		end else if (op_q inside {OP_PROMOTE, OP_IS_VALID, OP_GET_PAYLOAD}) begin
			take = !sel_fnd_q && used_s1 && (seq_s1 == id_q);
		end else if (op_q inside {OP_GET_MAX, OP_POP_MAX}) begin
			take = used_s1 && (!sel_fnd_q || (pri_s1 > sel_pri_q) ||
				((pri_s1 == sel_pri_q) && (seq_s1 > sel_seq_q)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1    <= 1'b0;
			sel_fnd_q  <= 1'b0;
			next_seq_q <= '0;
		end else begin
			eval_s1 <= cmd.rd_en;
			if (cmd.start) begin
				sel_fnd_q <= 1'b0;
			end else if (eval_s1 && take) begin
				sel_fnd_q <= 1'b1;
			end
			if (cmd.commit && (op_q == OP_ADD) && sel_fnd_q) begin
				next_seq_q <= next_seq_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
		if (eval_s1 && take) begin
			sel_idx_q <= idx_s1;
			sel_pay_q <= pay_s1;
			sel_pri_q <= pri_s1;
			sel_seq_q <= seq_s1;
		end
	end

	assign pri_inc = (sel_pri_q == PRIO_MAX) ? sel_pri_q : sel_pri_q + 1'b1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sel_idx_q;
		wr_used = 1'b1;
		wr_pay  = sel_pay_q;
		wr_pri  = sel_pri_q;
		wr_seq  = sel_seq_q;
		if (cmd.clear_wr) begin
			wr_en   = 1'b1;
			wr_addr = addr;
			wr_used = 1'b0;
			wr_pay  = '0;
			wr_pri  = '0;
			wr_seq  = '0;
		end else if (cmd.commit && sel_fnd_q) begin
			case (op_q)
				OP_ADD: begin
					wr_en  = 1'b1;
					wr_pay = pay_q;
					wr_pri = '0;
					wr_seq = next_seq_q;
				end
				OP_PROMOTE: begin
					wr_en  = 1'b1;
					wr_pri = pri_inc;
				end
				OP_POP_MAX: begin
					wr_en   = 1'b1;
					wr_used = 1'b0;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_addr] <= wr_used;
			pay_mem[wr_addr]  <= wr_pay;
			pri_mem[wr_addr]  <= wr_pri;
			seq_mem[wr_addr]  <= wr_seq;
		end
		if (cmd.rd_en) begin
			used_s1 <= used_mem[addr];
			pay_s1  <= pay_mem[addr];
			pri_s1  <= pri_mem[addr];
			seq_s1  <= seq_mem[addr];
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_id     = '0;
		res_pay    = '0;
		res_pri    = '0;
		res_valid  = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (sel_fnd_q) begin
					res_id    = next_seq_q;
					res_valid = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_PROMOTE, OP_GET_PAYLOAD: begin
				res_id = id_q;
				if (sel_fnd_q) begin
					res_pay   = PORT_PAY_W'(sel_pay_q);
					res_pri   = (op_q == OP_PROMOTE) ? pri_inc : sel_pri_q;
					res_valid = 1'b1;
				end else begin
					res_status = ST_UNKNOWN;
				end
			end
			OP_GET_MAX, OP_POP_MAX, OP_IS_VALID: begin
				if (sel_fnd_q) begin
					res_id    = sel_seq_q;
					res_pay   = PORT_PAY_W'(sel_pay_q);
					res_pri   = sel_pri_q;
					res_valid = 1'b1;
				end else if (op_q != OP_IS_VALID) begin
					res_status = ST_EMPTY;
				end
			end
			default: res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status       <= res_status;
			id_out       <= res_id;
			payload_out  <= res_pay;
			priority_out <= res_pri;
			is_valid_out <= res_valid;
		end
	end

	assign stat.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/priority_table_with_promote.sv =====
// Max-priority table with promote. Each request is one operation on a table of
// CAPACITY slots (add, promote, get max, pop max, is valid, get payload) and
// returns exactly one response. Add stores a payload at priority 0 and returns a
// fresh 32-bit id (a wrapping sequence number); get/pop max pick the highest
// priority, newest id on a tie. Each request runs from acceptance to the next
// acceptance through these steps: take the request, read the slot table once
// per slot, let the last read land, then write back and load the response
// register. A response may wait in the output register while the next request
// is taken; the write back then holds until that response is taken. After reset
// the block clears every slot of the table and holds req.ready low meanwhile.
module priority_table_with_promote import ptp_pkg::*; #(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	ptp_req_if.sink    req,
	ptp_rsp_if.source  rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	cmd_t          cmd;
	stat_t         stat;
	logic [AW-1:0] addr;

	// Sequencer: clearing pass, slot scan, write back
	ptp_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd),
		.addr      (addr)
	);

	// Slot memory, selection trackers and response register
	ptp_dp #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.addr         (addr),
		.stat         (stat),
		.operation    (req.operation),
		.entry_id     (req.entry_id),
		.payload_in   (req.payload_in),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.status       (rsp.status),
		.id_out       (rsp.id_out),
		.payload_out  (rsp.payload_out),
		.priority_out (rsp.priority_out),
		.is_valid_out (rsp.is_valid_out)
	);

endmodule

// ===== rtl/ptp_chk.sv =====
module ptp_chk import ptp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input status_t               status,
	input id_t                   id_out,
	input logic [PORT_PAY_W-1:0] payload_out,
	input prio_t                 priority_out,
	input logic                  is_valid_out
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Track requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (!req_acc && rsp_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(id_out) &&
			$stable(payload_out) && $stable(priority_out) && $stable(is_valid_out))
		else $error("response changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while another is in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a request");

	a_bounded_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> pend_q < 2'd2)
		else $error("request taken with two outstanding");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> !is_valid_out && id_out == '0 &&
			payload_out == '0 && priority_out == '0)
		else $error("empty-table response carries data");

endmodule

bind priority_table_with_promote ptp_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.id_out       (rsp.id_out),
	.payload_out  (rsp.payload_out),
	.priority_out (rsp.priority_out),
	.is_valid_out (rsp.is_valid_out)
);
